### src/tme_pkg.sv
// package for the tape machine execute unit
// holds sizes, command codes and the transaction structs; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tme_pkg;

  localparam int TAPE_DEPTH = 32768;
  localparam int PTR_W      = $clog2(TAPE_DEPTH);

  localparam int CMD_W  = 4;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 12;
  localparam int NEXT_W = IDX_W + 1;
  localparam int BYTE_W = 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CMD_W-1:0] CMD_LEFT     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_ADD      = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SUBTRACT = 4'd3;
  localparam logic [CMD_W-1:0] CMD_INPUT    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_OUTPUT   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_OPEN     = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLOSE    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 4'd8;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  op_index;
    logic [IDX_W-1:0]  jump_target;
    logic [BYTE_W-1:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic [NEXT_W-1:0] next_index;
  } out_item_t;

endpackage

`default_nettype wire

### src/tme_tape_ram.sv
// generic single-write, single-read synchronous ram for the tape
// read data registered, old data returned on a same-address write; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tme_tape_ram #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/tme_result_fifo.sv
// small result queue that parts the execute stage from the output handshake
// depends on tme_pkg for out_item_t and the queue depth
`timescale 1ns / 1ps
`default_nettype none

module tme_result_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tme_pkg::out_item_t push_item,
  output logic [tme_pkg::FIFO_AW:0] level,
  output logic                   head_valid,
  input  wire logic              head_stall,
  output tme_pkg::out_item_t     head
);
  import tme_pkg::*;

  out_item_t          slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               pop;

  assign head_valid = (level != '0);
  assign head       = slots[rd_ptr];
  assign pop        = head_valid & ~head_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   level <= level + (FIFO_AW + 1)'(1);
        2'b01:   level <= level - (FIFO_AW + 1)'(1);
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

### src/tape_machine_execute_unit.sv
// a result transaction passes through the execute stage register and the result queue
//   before it is offered on res
// throughput: one command per cycle while cmd_stall is low; the tape ram read data is
//   registered, and the read-modify-write is covered by forwarding of the previous write
// reset: rst clears the pointer and control state, then a clearing pass zeroes
//   the tape one cell per cycle, with cmd_stall held high
`timescale 1ns / 1ps
`default_nettype none

module tape_machine_execute_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire tme_pkg::in_item_t cmd,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output tme_pkg::out_item_t     res
);
  import tme_pkg::*;

  // width that holds the pointer, the count and their sum without overflow
  localparam int SUM_W = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

  logic accept;

  // clearing pass after reset
  logic             clearing;
  logic [PTR_W-1:0] clr_addr;

  // data pointer, updated at accept so the next command reads the moved cell
  logic [PTR_W-1:0] ptr;
  logic [PTR_W-1:0] ptr_next;
  logic [SUM_W-1:0] cnt_ext;
  logic [SUM_W-1:0] ptr_ext;
  logic [SUM_W-1:0] room_ext;

  // execute stage: command is held here for the registered ram read data
  logic              s1_valid;
  logic [CMD_W-1:0]  s1_cmd;
  logic [BYTE_W-1:0] s1_cnt;
  logic [PTR_W-1:0]  s1_addr;
  logic [BYTE_W-1:0] s1_in_byte;
  logic [IDX_W-1:0]  s1_idx;
  logic [IDX_W-1:0]  s1_tgt;

  // last write, seen by a read issued in the same cycle
  logic              fwd_valid;
  logic [PTR_W-1:0]  fwd_addr;
  logic [BYTE_W-1:0] fwd_data;

  // tape ram ports
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;

  logic              cell_we;
  logic [BYTE_W-1:0] cell_cur;
  logic [BYTE_W-1:0] cell_new;
  logic              taken;
  out_item_t         s1_res;

  logic [FIFO_AW:0]  fifo_level;

  // room is checked against the queue and the command already in flight
  assign cmd_stall = clearing |
                     (((FIFO_AW + 1)'(fifo_level) + (FIFO_AW + 1)'(s1_valid))
                      >= (FIFO_AW + 1)'(FIFO_DEPTH));
  assign accept    = cmd_valid & ~cmd_stall;

  // clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + PTR_W'(1);
      if (clr_addr == PTR_W'(TAPE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // pointer moves, left clamps at zero, right saturates at the tape end
  always_comb begin
    cnt_ext  = SUM_W'(cmd.count);
    ptr_ext  = SUM_W'(ptr);
    room_ext = SUM_W'(TAPE_DEPTH - 1) - ptr_ext;
    ptr_next = ptr;
    if (accept) begin
      priority if (cmd.command == CMD_LEFT) begin
        ptr_next = (cnt_ext >= ptr_ext) ? '0 : PTR_W'(ptr_ext - cnt_ext);
      end else if (cmd.command == CMD_RIGHT) begin
        ptr_next = (cnt_ext >= room_ext) ? PTR_W'(TAPE_DEPTH - 1)
                                         : PTR_W'(ptr_ext + cnt_ext);
      end else begin
        ptr_next = ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      s1_valid <= 1'b0;
    end else begin
      ptr      <= ptr_next;
      s1_valid <= accept;
    end
  end

  // payload of the execute stage, the cell address is the pointer before any move
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd     <= cmd.command;
      s1_cnt     <= cmd.count[BYTE_W-1:0];
      s1_addr    <= ptr;
      s1_in_byte <= cmd.in_byte;
      s1_idx     <= cmd.op_index;
      s1_tgt     <= cmd.jump_target;
    end
  end

  // cell value, taking the write made while this read was issued
  assign cell_cur = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : ram_rdata;

  always_comb begin
    cell_we  = 1'b0;
    cell_new = cell_cur;
    taken    = 1'b0;
    unique case (s1_cmd)
      CMD_ADD: begin
        cell_we  = 1'b1;
        cell_new = cell_cur + s1_cnt;
      end
      CMD_SUBTRACT: begin
        cell_we  = 1'b1;
        cell_new = cell_cur - s1_cnt;
      end
      CMD_INPUT: begin
        cell_we  = 1'b1;
        cell_new = s1_in_byte;
      end
      CMD_CLEAR: begin
        cell_we  = 1'b1;
        cell_new = '0;
      end
      CMD_OPEN:  taken = (cell_cur == '0);
      CMD_CLOSE: taken = (cell_cur != '0);
      default: begin
        cell_we  = 1'b0;
        cell_new = cell_cur;
      end
    endcase
  end

  always_comb begin
    s1_res.out_valid  = (s1_cmd == CMD_OUTPUT);
    s1_res.out_byte   = s1_res.out_valid ? cell_cur : '0;
    s1_res.next_index = (taken ? NEXT_W'(s1_tgt) : NEXT_W'(s1_idx)) + NEXT_W'(1);
  end

  // write port: clearing pass first, then the execute stage
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_valid & cell_we;
      ram_waddr = s1_addr;
      ram_wdata = cell_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_valid & cell_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1_addr;
    fwd_data <= cell_new;
  end

  tme_tape_ram #(
    .DEPTH (TAPE_DEPTH),
    .WIDTH (BYTE_W),
    .AW    (PTR_W)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  // every execute-stage result is queued; the stall above keeps room for it
  tme_result_fifo u_results (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_item  (s1_res),
    .level      (fifo_level),
    .head_valid (res_valid),
    .head_stall (res_stall),
    .head       (res)
  );

`ifndef SYNTHESIS
  // an execute-stage command was accepted in the cycle before
  a_s1_from_accept: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(cmd_valid && !cmd_stall))
    else $error("execute stage valid without an accepted command");

  // pointer stays on the tape
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PTR_W'(TAPE_DEPTH - 1))
    else $error("data pointer beyond the tape end");

  // no command in flight while the tape is being cleared
  a_no_exec_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_valid && !fwd_valid))
    else $error("command executed during the clearing pass");

  // the result queue never overflows
  a_fifo_room: assert property (@(posedge clk) disable iff (rst)
    fifo_level <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue overflow");
`endif

endmodule

`default_nettype wire
